// ===== src/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants for the byte and substring search
// Holds the search mode codes, register indexes, the configuration record
// and the records passed between the search modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned PAT_BYTES    = 16;
  localparam int unsigned PAT_INDEX_W  = 4;
  localparam int unsigned LENGTH_W     = 5;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned POS_FIELD_W  = 32;

  // Search modes. The unused code falls back to an exact byte compare.
  localparam logic [MODE_W-1:0] MODE_EXACT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NOCASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUBSTR = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]              mode;
    logic [LENGTH_W-1:0]            length;
    logic [PAT_BYTES-1:0][7:0]      pattern;
  } cfg_t;

  typedef struct packed {
    logic                   hit;
    logic [POS_FIELD_W-1:0] position;
  } match_t;

  typedef struct packed {
    logic       step;
    logic       last;
    logic       hit;
    logic [7:0] cur;
  } win_ctl_t;

endpackage

`default_nettype wire

// ===== src/bss_in_if.sv =====
// ----------------------------------------------------------------------------
// bss_in_if: text byte channel
// Carries one text byte and its end-of-text flag per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== src/bss_out_if.sv =====
// ----------------------------------------------------------------------------
// bss_out_if: search result channel
// Carries the found flag and the match position per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink   (input valid, input found, input match_position, output ready);
endinterface

`default_nettype wire

// ===== src/byte_and_substring_search.sv =====
// ----------------------------------------------------------------------------
// byte_and_substring_search: first-match byte and substring search
// Streams text bytes and reports the first offset where the pattern occurs.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while no byte with a result is held
// for the output register, and gives at most one result word per text: at the
// first match, or at the last byte if nothing matched. A byte is registered on
// acceptance, compared against the pattern by a single pass over the window
// while it sits in that register, and its result is written into the output
// register when the byte moves on. Throughput is one byte per clock; the
// output register lets the next byte in while a result waits, and a byte that
// would produce a result waits only while the output register is still full.
// There is no clearing pass after reset. Search modes: 0 exact byte, 1 ASCII
// case-insensitive byte, 2 substring of up to PATTERN_MAX bytes; mode 3 acts
// as mode 0. Configuration must be written only while no text is in flight.
`default_nettype none

module byte_and_substring_search #(
  parameter int unsigned PATTERN_MAX   = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  bss_in_if.sink                                   in_chan,
  bss_out_if.source                                out_chan,
  input  wire logic                                cfg_we,
  input  wire logic [bss_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [bss_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  bss_pkg::cfg_t    cfg_r, cfg_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r;
  logic [31:0]      out_pos_r;

  logic [PATTERN_MAX-2:0][7:0]  window;
  logic [POSITION_BITS-1:0]     seen;
  logic                         done;
  bss_pkg::match_t              result;
  bss_pkg::win_ctl_t            win_ctl;

  logic in_acc;
  logic produces;
  logic slot_free;
  logic advance;

  // Configuration registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        bss_pkg::REG_SEARCH_MODE:  cfg_nxt.mode   = cfg_wdata[bss_pkg::MODE_W-1:0];
        bss_pkg::REG_PATTERN_LEN:  cfg_nxt.length = cfg_wdata[bss_pkg::LENGTH_W-1:0];
        bss_pkg::REG_PATTERN_LOW:  cfg_nxt.pattern[7:0]  = cfg_wdata;
        bss_pkg::REG_PATTERN_HIGH: cfg_nxt.pattern[15:8] = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= bss_pkg::MODE_EXACT;
      cfg_r.length  <= bss_pkg::LENGTH_W'(1);
      cfg_r.pattern <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A registered byte moves on unless it has a result and the output
  // register is still holding the previous one.
  assign produces  = result.hit || (s1_last_r && !done);
  assign slot_free = !out_valid_r || out_chan.ready;
  assign advance   = s1_valid_r && (!produces || slot_free);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_acc    = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_chan.text_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  assign win_ctl.step = advance;
  assign win_ctl.last = s1_last_r;
  assign win_ctl.hit  = result.hit;
  assign win_ctl.cur  = s1_byte_r;

  bss_window #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (win_ctl),
    .window (window),
    .seen   (seen),
    .done   (done)
  );

  bss_match #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_match (
    .cfg    (cfg_r),
    .cur    (s1_byte_r),
    .window (window),
    .seen   (seen),
    .done   (done),
    .result (result)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && produces) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produces) begin
      out_found_r <= result.hit;
      out_pos_r   <= result.position;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.found          = out_found_r;
  assign out_chan.match_position = out_pos_r;

endmodule

`default_nettype wire

// ===== src/bss_window.sv =====
// ----------------------------------------------------------------------------
// bss_window: per-text search state
// Keeps the recent byte window, the saturating byte count and the flag that
// a match was already reported, and updates them as each byte is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_window #(
  parameter int unsigned PATTERN_MAX   = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire bss_pkg::win_ctl_t                   ctl,
  output logic [PATTERN_MAX-2:0][7:0]              window,
  output logic [POSITION_BITS-1:0]                 seen,
  output logic                                     done
);

  localparam int unsigned WIN_DEPTH = PATTERN_MAX - 1;

  logic [WIN_DEPTH-1:0][7:0]  recent_r, recent_nxt;
  logic [POSITION_BITS-1:0]   seen_r, seen_nxt;
  logic                       done_r, done_nxt;

  always_comb begin
    recent_nxt = recent_r;
    seen_nxt   = seen_r;
    done_nxt   = done_r;
    if (ctl.step) begin
      if (ctl.last) begin
        recent_nxt = '0;
        seen_nxt   = '0;
        done_nxt   = 1'b0;
      end else if (ctl.hit) begin
        done_nxt = 1'b1;
      end else if (!done_r) begin
        recent_nxt[0] = ctl.cur;
        for (int i = 1; i < WIN_DEPTH; i++) begin
          recent_nxt[i] = recent_r[i-1];
        end
        if (!(&seen_r)) begin
          seen_nxt = seen_r + POSITION_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      seen_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      recent_r <= recent_nxt;
      seen_r   <= seen_nxt;
      done_r   <= done_nxt;
    end
  end

  assign window = recent_r;
  assign seen   = seen_r;
  assign done   = done_r;

endmodule

`default_nettype wire

// ===== src/bss_match.sv =====
// ----------------------------------------------------------------------------
// bss_match: pattern compare
// Compares the current byte and the window against the configured pattern
// and works out the match start position.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_match #(
  parameter int unsigned PATTERN_MAX   = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire bss_pkg::cfg_t                   cfg,
  input  wire logic [7:0]                      cur,
  input  wire logic [PATTERN_MAX-2:0][7:0]     window,
  input  wire logic [POSITION_BITS-1:0]        seen,
  input  wire logic                            done,
  output bss_pkg::match_t                      result
);

  localparam int unsigned IDX_W = $clog2(PATTERN_MAX);
  localparam int unsigned EXT_W = (POSITION_BITS > bss_pkg::POS_FIELD_W) ?
                                  POSITION_BITS : bss_pkg::POS_FIELD_W;
  // Set for a 64-bit count; a saturated count then never counts as enough bytes seen.
  localparam bit COUNT_WRAPS = (POSITION_BITS == 64);

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'd32;
    end
    return b;
  endfunction

  logic [PATTERN_MAX-1:0][7:0]  bytes_back;
  logic [IDX_W-1:0]             len_m1;
  logic                         all_eq;
  logic                         enough;
  logic                         hit;
  logic [POSITION_BITS-1:0]     start;
  logic [EXT_W-1:0]             start_ext;
  logic [bss_pkg::POS_FIELD_W-1:0] start_clamped;

  // Index 0 is the current byte, index d is the byte d places back.
  assign bytes_back = {window, cur};

  always_comb begin
    len_m1 = '0;
    if (cfg.mode == bss_pkg::MODE_SUBSTR) begin
      if (cfg.length == '0) begin
        len_m1 = '0;
      end else if (cfg.length > bss_pkg::LENGTH_W'(PATTERN_MAX)) begin
        len_m1 = IDX_W'(PATTERN_MAX - 1);
      end else begin
        len_m1 = IDX_W'(cfg.length - bss_pkg::LENGTH_W'(1));
      end
    end
  end

  always_comb begin
    all_eq = 1'b1;
    for (int d = 0; d < PATTERN_MAX; d++) begin
      if (IDX_W'(d) <= len_m1) begin
        if (bytes_back[d] !=
            cfg.pattern[bss_pkg::PAT_INDEX_W'(len_m1 - IDX_W'(d))]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign enough = (seen >= POSITION_BITS'(len_m1)) && !(COUNT_WRAPS && (&seen));

  always_comb begin
    if (done) begin
      hit = 1'b0;
    end else if (cfg.mode == bss_pkg::MODE_NOCASE) begin
      hit = (fold_case(cur) == fold_case(cfg.pattern[0]));
    end else begin
      hit = enough && all_eq;
    end
  end

  assign start     = (&seen) ? seen : (seen - POSITION_BITS'(len_m1));
  assign start_ext = EXT_W'(start);
  assign start_clamped = (start_ext > EXT_W'(32'hFFFF_FFFF)) ? '1 :
                         start_ext[bss_pkg::POS_FIELD_W-1:0];

  assign result.hit      = hit;
  assign result.position = hit ? start_clamped : '0;

endmodule

`default_nettype wire
